// ===== design/ssi_pkg.sv =====
package ssi_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int TOL_BITS = 8;
	localparam logic [TOL_BITS-1:0] TOL_RESET = 8'd2;

endpackage

// ===== design/segment_sphere_intersect.sv =====
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid/in_ready   | start_*, end_*, center_*, radius
// out     | output    | out_valid/out_ready | hit, degenerate
// cfg     | input     | cfg_we              | cfg_wdata (on_line_tolerance)
//
// One item per cycle while the output is not stalled; the pipeline has five setup
// stages, a restoring divider of COORD_BITS+2 stages, three squaring stages, a square
// root of COORD_BITS+4 stages and the output register.
// arst_n clears every valid bit and loads the tolerance with its reset value.
// A stall at the output freezes the whole pipeline, so nothing is dropped or repeated.
module segment_sphere_intersect #(
	parameter int COORD_BITS = ssi_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ssi_pkg::TOL_BITS-1:0]      cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [COORD_BITS-1:0]      start_x,
	input  logic signed [COORD_BITS-1:0]      start_y,
	input  logic signed [COORD_BITS-1:0]      start_z,
	input  logic signed [COORD_BITS-1:0]      end_x,
	input  logic signed [COORD_BITS-1:0]      end_y,
	input  logic signed [COORD_BITS-1:0]      end_z,
	input  logic signed [COORD_BITS-1:0]      center_x,
	input  logic signed [COORD_BITS-1:0]      center_y,
	input  logic signed [COORD_BITS-1:0]      center_z,
	input  logic [COORD_BITS-2:0]             radius,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              hit,
	output logic                              degenerate
);
	import ssi_pkg::*;

	localparam int C   = COORD_BITS;
	localparam int DW  = C + 1;         // coordinate differences
	localparam int PW  = 2 * DW;        // their products
	localparam int SW  = 2 * C + 4;     // squared lengths and the dot product
	localparam int MW  = SW + DW;       // dot * d
	localparam int N   = C + 2;         // quotient bits, root bits of the length
	localparam int QW  = C + 3;         // signed quotient and offsets from it
	localparam int SW2 = 2 * QW + 2;    // squared distances from the projected point
	localparam int N2  = QW + 1;        // root bits of those distances
	localparam int RW  = C - 1;
	localparam int CW  = N2 + 2;

	typedef struct packed {
		logic                  vld;
		logic                  early;
		logic                  degen;
		logic [RW-1:0]         r;
		logic [2:0][DW-1:0]    d;
		logic [2:0][DW-1:0]    u;
		logic [2:0][MW:0]      rem;
		logic [2:0][N-1:0]     q;
		logic [2:0]            neg;
		logic [SW-1:0]         len2;
		logic [SW:0]           lrem;
		logic [N-1:0]          lroot;
	} div_t;

	typedef struct packed {
		logic                  vld;
		logic                  early;
		logic                  degen;
		logic [RW-1:0]         r;
		logic [N-1:0]          len;
		logic [2:0][SW2:0]     rem;
		logic [2:0][N2-1:0]    root;
	} sqr_t;

	logic [TOL_BITS-1:0] tol_q;
	logic adv;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	// Advance every stage together whenever the output slot is free or being taken
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// Stage 1: differences e-s, c-s, c-e
	logic signed [DW-1:0] sx, sy, sz, ex, ey, ez, cx, cy, cz;
	assign sx = {start_x[C-1], start_x};
	assign sy = {start_y[C-1], start_y};
	assign sz = {start_z[C-1], start_z};
	assign ex = {end_x[C-1], end_x};
	assign ey = {end_y[C-1], end_y};
	assign ez = {end_z[C-1], end_z};
	assign cx = {center_x[C-1], center_x};
	assign cy = {center_y[C-1], center_y};
	assign cz = {center_z[C-1], center_z};

	logic                   vld_s1;
	logic [2:0][DW-1:0]     d_s1, u_s1, v_s1;
	logic [RW-1:0]          r_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1  <= in_valid;
			d_s1[0] <= ex - sx;
			d_s1[1] <= ey - sy;
			d_s1[2] <= ez - sz;
			u_s1[0] <= cx - sx;
			u_s1[1] <= cy - sy;
			u_s1[2] <= cz - sz;
			v_s1[0] <= cx - ex;
			v_s1[1] <= cy - ey;
			v_s1[2] <= cz - ez;
			r_s1    <= radius;
		end
	end

	// Stage 2: squares, the dot product terms and r*r
	logic                   vld_s2;
	logic [2:0][PW-1:0]     dd_s2, uu_s2, vv_s2, ud_s2;
	logic [2:0][DW-1:0]     d_s2, u_s2;
	logic [RW-1:0]          r_s2;
	logic [2*RW-1:0]        rr_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
			for (int i = 0; i < 3; i++) begin
				dd_s2[i] <= $signed(d_s1[i]) * $signed(d_s1[i]);
				uu_s2[i] <= $signed(u_s1[i]) * $signed(u_s1[i]);
				vv_s2[i] <= $signed(v_s1[i]) * $signed(v_s1[i]);
				ud_s2[i] <= $signed(u_s1[i]) * $signed(d_s1[i]);
			end
			d_s2  <= d_s1;
			u_s2  <= u_s1;
			r_s2  <= r_s1;
			rr_s2 <= r_s1 * r_s1;
		end
	end

	// Stage 3: sums of three
	logic                   vld_s3;
	logic [SW-1:0]          len2_s3, su_s3, sv_s3;
	logic signed [SW-1:0]   dot_s3;
	logic [2:0][DW-1:0]     d_s3, u_s3;
	logic [RW-1:0]          r_s3;
	logic [2*RW-1:0]        rr_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3  <= vld_s2;
			len2_s3 <= SW'(dd_s2[0]) + SW'(dd_s2[1]) + SW'(dd_s2[2]);
			su_s3   <= SW'(uu_s2[0]) + SW'(uu_s2[1]) + SW'(uu_s2[2]);
			sv_s3   <= SW'(vv_s2[0]) + SW'(vv_s2[1]) + SW'(vv_s2[2]);
			dot_s3  <= SW'($signed(ud_s2[0])) + SW'($signed(ud_s2[1]))
				+ SW'($signed(ud_s2[2]));
			d_s3    <= d_s2;
			u_s3    <= u_s2;
			r_s3    <= r_s2;
			rr_s3   <= rr_s2;
		end
	end

	// Stage 4: endpoint tests, degenerate flag, dot * d
	logic                   vld_s4, early_s4, degen_s4;
	logic [2:0][MW-1:0]     m_s4;
	logic [SW-1:0]          len2_s4;
	logic [2:0][DW-1:0]     d_s4, u_s4;
	logic [RW-1:0]          r_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4   <= vld_s3;
			early_s4 <= (su_s3 <= SW'(rr_s3)) || (sv_s3 <= SW'(rr_s3));
			degen_s4 <= (len2_s3 == '0);
			for (int i = 0; i < 3; i++) begin
				m_s4[i] <= dot_s3 * $signed(d_s3[i]);
			end
			len2_s4 <= len2_s3;
			d_s4    <= d_s3;
			u_s4    <= u_s3;
			r_s4    <= r_s3;
		end
	end

	// Stage 5 and the divider: one quotient bit per stage, root of len2 alongside
	div_t div_s [0:N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_s[0].vld <= 1'b0;
		end else if (adv) begin
			div_s[0].vld   <= vld_s4;
			div_s[0].early <= early_s4;
			div_s[0].degen <= degen_s4;
			div_s[0].r     <= r_s4;
			div_s[0].d     <= d_s4;
			div_s[0].u     <= u_s4;
			for (int i = 0; i < 3; i++) begin
				div_s[0].neg[i] <= m_s4[i][MW-1];
				div_s[0].rem[i] <= m_s4[i][MW-1] ? {1'b0, -m_s4[i]} : {1'b0, m_s4[i]};
				div_s[0].q[i]   <= '0;
			end
			div_s[0].len2  <= len2_s4;
			div_s[0].lrem  <= {1'b0, len2_s4};
			div_s[0].lroot <= '0;
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_div
		localparam int B = N - 1 - k;
		div_t nxt;
		logic [MW:0] dsh;
		logic [SW:0] t;

		always_comb begin
			nxt = div_s[k];
			dsh = (MW+1)'(div_s[k].len2) << B;
			for (int i = 0; i < 3; i++) begin
				if (div_s[k].rem[i] >= dsh) begin
					nxt.rem[i]  = div_s[k].rem[i] - dsh;
					nxt.q[i][B] = 1'b1;
				end
			end
			t = ((SW+1)'(div_s[k].lroot) << (B + 1)) | ((SW+1)'(1) << (2 * B));
			if (div_s[k].lrem >= t) begin
				nxt.lrem     = div_s[k].lrem - t;
				nxt.lroot[B] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_s[k+1].vld <= 1'b0;
			end else if (adv) begin
				div_s[k+1] <= nxt;
			end
		end
	end

	// Stage 6: signed quotient gives p-s; form p-e and p-c
	logic                   vld_s6, early_s6, degen_s6;
	logic [2:0][QW-1:0]     a_s6, b_s6, g_s6;
	logic [RW-1:0]          r_s6;
	logic [N-1:0]           len_s6;
	logic signed [QW-1:0]   qs [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qs[i] = div_s[N].neg[i] ? -$signed(QW'(div_s[N].q[i]))
				: $signed(QW'(div_s[N].q[i]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s6   <= div_s[N].vld;
			early_s6 <= div_s[N].early;
			degen_s6 <= div_s[N].degen;
			r_s6     <= div_s[N].r;
			len_s6   <= div_s[N].lroot;
			for (int i = 0; i < 3; i++) begin
				a_s6[i] <= qs[i];
				b_s6[i] <= qs[i] - QW'($signed(div_s[N].d[i]));
				g_s6[i] <= qs[i] - QW'($signed(div_s[N].u[i]));
			end
		end
	end

	// Stage 7: squares
	logic                   vld_s7, early_s7, degen_s7;
	logic [2:0][2*QW-1:0]   aa_s7, bb_s7, gg_s7;
	logic [RW-1:0]          r_s7;
	logic [N-1:0]           len_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s7   <= vld_s6;
			early_s7 <= early_s6;
			degen_s7 <= degen_s6;
			r_s7     <= r_s6;
			len_s7   <= len_s6;
			for (int i = 0; i < 3; i++) begin
				aa_s7[i] <= $signed(a_s6[i]) * $signed(a_s6[i]);
				bb_s7[i] <= $signed(b_s6[i]) * $signed(b_s6[i]);
				gg_s7[i] <= $signed(g_s6[i]) * $signed(g_s6[i]);
			end
		end
	end

	// Stage 8 and the square roots: one root bit per stage in three lanes
	sqr_t sqr_s [0:N2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sqr_s[0].vld <= 1'b0;
		end else if (adv) begin
			sqr_s[0].vld    <= vld_s7;
			sqr_s[0].early  <= early_s7;
			sqr_s[0].degen  <= degen_s7;
			sqr_s[0].r      <= r_s7;
			sqr_s[0].len    <= len_s7;
			sqr_s[0].rem[0] <= (SW2+1)'(aa_s7[0]) + (SW2+1)'(aa_s7[1])
				+ (SW2+1)'(aa_s7[2]);
			sqr_s[0].rem[1] <= (SW2+1)'(bb_s7[0]) + (SW2+1)'(bb_s7[1])
				+ (SW2+1)'(bb_s7[2]);
			sqr_s[0].rem[2] <= (SW2+1)'(gg_s7[0]) + (SW2+1)'(gg_s7[1])
				+ (SW2+1)'(gg_s7[2]);
			sqr_s[0].root   <= '0;
		end
	end

	for (genvar k = 0; k < N2; k++) begin : g_sqr
		localparam int B = N2 - 1 - k;
		sqr_t nxt;
		logic [SW2:0] t [3];

		always_comb begin
			nxt = sqr_s[k];
			for (int i = 0; i < 3; i++) begin
				t[i] = ((SW2+1)'(sqr_s[k].root[i]) << (B + 1)) | ((SW2+1)'(1) << (2 * B));
				if (sqr_s[k].rem[i] >= t[i]) begin
					nxt.rem[i]     = sqr_s[k].rem[i] - t[i];
					nxt.root[i][B] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sqr_s[k+1].vld <= 1'b0;
			end else if (adv) begin
				sqr_s[k+1] <= nxt;
			end
		end
	end

	// Output register: tolerance window and radius test
	sqr_t        fin;
	logic [CW-1:0] dsum, lenw, tolw;
	logic        on_seg;

	always_comb begin
		fin    = sqr_s[N2];
		dsum   = CW'(fin.root[0]) + CW'(fin.root[1]);
		lenw   = CW'(fin.len);
		tolw   = CW'(tol_q);
		on_seg = (dsum + tolw >= lenw) && (dsum <= lenw + tolw)
			&& (CW'(fin.root[2]) <= CW'(fin.r));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid  <= fin.vld;
			hit        <= fin.early || (!fin.degen && on_seg);
			degenerate <= fin.degen;
		end
	end

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB = ssi_pkg::COORD_BITS_DEF;
	// pipeline depth summed from the stages in the block's header: 2*COORD_BITS + 15
	localparam int PIPE_DEPTH = 2 * CB + 15;

	typedef logic signed [CB-1:0] coord_t;
	typedef longint vec3_t[3];

	typedef struct {
		coord_t sx, sy, sz;
		coord_t ex, ey, ez;
		coord_t cx, cy, cz;
		logic [CB-2:0] rad;
	} seg_query_t;

	// one expected verdict per transfer: {hit, degenerate}
	typedef struct {
		logic hit;
		logic degen;
	} verdict_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [ssi_pkg::TOL_BITS-1:0] cfg_wdata;
	logic in_valid;
	logic in_ready;
	coord_t start_x, start_y, start_z;
	coord_t end_x, end_y, end_z;
	coord_t center_x, center_y, center_z;
	logic [CB-2:0] radius;
	logic out_valid;
	logic out_ready;
	logic hit;
	logic degenerate;

	// tolerance as the block currently holds it
	logic [ssi_pkg::TOL_BITS-1:0] tol_now;

	verdict_t verdict_q[$];
	int error_count;

	// idling percentages for each side
	int tx_idle_pct;
	int rx_stall_pct;

	// long receiver hold-off: the test bumps the request count, the ready
	// process notices and counts the stretch down itself
	int hold_request;
	int hold_len;

	segment_sphere_intersect #(
		.COORD_BITS(CB)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.start_x   (start_x),
		.start_y   (start_y),
		.start_z   (start_z),
		.end_x     (end_x),
		.end_y     (end_y),
		.end_z     (end_z),
		.center_x  (center_x),
		.center_y  (center_y),
		.center_z  (center_z),
		.radius    (radius),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.hit       (hit),
		.degenerate(degenerate)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Geometry predictor: exact integer arithmetic on raw coordinates.
	// Every intermediate fits comfortably in 64 bits at 16-bit coordinates.
	// ------------------------------------------------------------------

	// truncated integer square root
	function automatic longint trunc_sqrt(longint n);
		longint r;
		longint c;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			c = r | (longint'(1) << b);
			if (c * c <= n)
				r = c;
		end
		return r;
	endfunction

	function automatic longint dist_sq(vec3_t a, vec3_t b);
		longint acc;
		acc = 0;
		for (int i = 0; i < 3; i++)
			acc += (a[i] - b[i]) * (a[i] - b[i]);
		return acc;
	endfunction

	function automatic verdict_t predict_intersection(seg_query_t q,
			logic [ssi_pkg::TOL_BITS-1:0] tol);
		vec3_t s, e, c, d, p;
		longint r, rr, len2, dot, len, dsum, t;
		verdict_t v;
		s = '{q.sx, q.sy, q.sz};
		e = '{q.ex, q.ey, q.ez};
		c = '{q.cx, q.cy, q.cz};
		r = longint'(q.rad);
		t = longint'(tol);
		rr = r * r;
		len2 = dist_sq(e, s);
		v.degen = (len2 == 0);
		v.hit = 1'b0;
		if (dist_sq(s, c) <= rr || dist_sq(e, c) <= rr) begin
			v.hit = 1'b1;
		end else if (!v.degen) begin
			dot = 0;
			for (int i = 0; i < 3; i++) begin
				d[i] = e[i] - s[i];
				dot += (c[i] - s[i]) * d[i];
			end
			// quotient truncates toward zero, as SV signed division does
			for (int i = 0; i < 3; i++)
				p[i] = s[i] + (dot * d[i]) / len2;
			len = trunc_sqrt(len2);
			dsum = trunc_sqrt(dist_sq(p, s)) + trunc_sqrt(dist_sq(p, e));
			if (dsum + t >= len && dsum <= len + t && trunc_sqrt(dist_sq(p, c)) <= r)
				v.hit = 1'b1;
		end
		return v;
	endfunction

	// ------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------

	task automatic report_mismatch(string what, logic got, logic want);
		$display("%0t mismatch on %s: got %0b, expected %0b", $realtime, what, got, want);
		error_count++;
	endtask

	// check every result transfer against the oldest verdict still waiting
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && out_valid && out_ready) begin
			if (verdict_q.size() == 0) begin
				$display("%0t result transfer with nothing outstanding", $realtime);
				error_count++;
			end else begin
				want = verdict_q.pop_front();
				if (hit !== want.hit)
					report_mismatch("hit", hit, want.hit);
				if (degenerate !== want.degen)
					report_mismatch("degenerate", degenerate, want.degen);
			end
		end
	end

	// receiver ready: random stalls, plus a counted hold-off on request
	always @(posedge clk or negedge arst_n) begin
		int hold_seen;
		int hold_left;
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_seen = 0;
			hold_left = 0;
		end else begin
			if (hold_request != hold_seen) begin
				hold_seen = hold_request;
				hold_left = hold_len;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	// ------------------------------------------------------------------
	// Send side
	// ------------------------------------------------------------------

	// offer one query, hold it until the transfer, and record its verdict;
	// valid stays high afterwards so back-to-back items need no gap
	task automatic send_query(seg_query_t q);
		int gap;
		gap = 0;
		while ($urandom_range(99) < tx_idle_pct && gap < 20)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		start_x <= q.sx;
		start_y <= q.sy;
		start_z <= q.sz;
		end_x <= q.ex;
		end_y <= q.ey;
		end_z <= q.ez;
		center_x <= q.cx;
		center_y <= q.cy;
		center_z <= q.cz;
		radius <= q.rad;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		verdict_q.push_back(predict_intersection(q, tol_now));
	endtask

	// drop valid and wait until every verdict has come back, then let the
	// pipeline run empty
	task automatic drain;
		in_valid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 5) @(posedge clk);
	endtask

	task automatic write_tolerance(logic [ssi_pkg::TOL_BITS-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		tol_now = value;
	endtask

	function automatic seg_query_t make_query(int s0, int s1, int s2, int e0, int e1,
			int e2, int c0, int c1, int c2, int rad);
		seg_query_t q;
		q.sx = coord_t'(s0);
		q.sy = coord_t'(s1);
		q.sz = coord_t'(s2);
		q.ex = coord_t'(e0);
		q.ey = coord_t'(e1);
		q.ez = coord_t'(e2);
		q.cx = coord_t'(c0);
		q.cy = coord_t'(c1);
		q.cz = coord_t'(c2);
		q.rad = rad[CB-2:0];
		return q;
	endfunction

	function automatic int rand_signed(int span);
		return int'($urandom_range(2 * span)) - span;
	endfunction

	// random query: mostly well-formed near misses and near hits, some noise
	function automatic seg_query_t random_query();
		seg_query_t q;
		int s[3], e[3], c[3];
		int span, k, rad, off, len;
		int kind;
		kind = $urandom_range(9);
		span = ($urandom_range(3) == 0) ? 16000 : 1500;
		rad = $urandom_range(span / 3);
		for (int i = 0; i < 3; i++) begin
			s[i] = rand_signed(span);
			e[i] = rand_signed(span);
		end
		k = int'($urandom_range(12)) - 2;
		off = rad + rad / 2 + 1;
		for (int i = 0; i < 3; i++)
			c[i] = s[i] + (e[i] - s[i]) * k / 8 + rand_signed(off);
		case (kind)
			0, 1: begin
				// raw noise over the full field ranges
				for (int i = 0; i < 3; i++) begin
					s[i] = int'($urandom_range(16'hffff));
					e[i] = int'($urandom_range(16'hffff));
					c[i] = int'($urandom_range(16'hffff));
				end
				rad = $urandom_range(15'h7fff);
			end
			7: begin
				// zero-length segment; the centre stays where it was placed for the original end
				for (int i = 0; i < 3; i++)
					e[i] = s[i];
			end
			8: begin
				// axis-aligned, centre beyond an end: probes the tolerance window
				len = $urandom_range(1, 2000);
				s = '{0, 0, 0};
				e = '{0, 0, 0};
				e[kind % 3] = len;
				c = '{0, 0, 0};
				c[kind % 3] = len + int'($urandom_range(1, 300));
				c[(kind + 1) % 3] = rand_signed(4);
				rad = $urandom_range(300);
			end
			default: ;
		endcase
		q = make_query(s[0], s[1], s[2], e[0], e[1], e[2], c[0], c[1], c[2], rad);
		return q;
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	task automatic test_directed;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		// extremes of every field
		send_query(make_query(-32768, -32768, -32768, 32767, 32767, 32767,
			-32768, 32767, -32768, 32767));
		send_query(make_query(32767, 32767, 32767, -32768, -32768, -32768,
			32767, -32768, 32767, 0));
		send_query(make_query(-32768, -32768, -32768, 32767, 32767, 32767,
			0, 0, 0, 0));
		send_query(make_query(-32768, 0, 0, 32767, 0, 0, 0, 32767, 0, 32767));
		// zero-length segment: endpoint inside, exactly on the surface, outside
		send_query(make_query(100, 100, 100, 100, 100, 100, 110, 100, 100, 20));
		send_query(make_query(100, 100, 100, 100, 100, 100, 120, 100, 100, 20));
		send_query(make_query(100, 100, 100, 100, 100, 100, 121, 100, 100, 20));
		send_query(make_query(-32768, -32768, -32768, -32768, -32768, -32768,
			32767, 32767, 32767, 32767));
		// start inside, end inside
		send_query(make_query(0, 0, 0, 5000, 0, 0, 3, 4, 0, 5));
		send_query(make_query(0, 0, 0, 5000, 0, 0, 4997, 4, 0, 5));
		// centre over the middle: hit, tangent, just clear
		send_query(make_query(0, 0, 0, 1600, 0, 0, 800, 50, 0, 60));
		send_query(make_query(0, 0, 0, 1600, 0, 0, 800, 0, 60, 60));
		send_query(make_query(0, 0, 0, 1600, 0, 0, 800, 61, 0, 60));
		// segments along z and slanted, using z in the projection
		send_query(make_query(0, 0, -800, 0, 0, 800, 30, 0, 200, 40));
		send_query(make_query(-500, 300, -700, 900, -400, 1100, 200, -50, 200, 90));
		// projection beyond an end: the first two depend on the tolerance
		send_query(make_query(0, 0, 0, 1600, 0, 0, 1700, 0, 0, 50));
		send_query(make_query(0, 0, 0, 1600, 0, 0, 1602, 0, 0, 1));
		send_query(make_query(0, 0, 0, 1600, 0, 0, -150, 0, 0, 60));
		drain();
	endtask

	task automatic test_tolerance_sweep;
		logic [ssi_pkg::TOL_BITS-1:0] settings[4];
		settings = '{8'd0, 8'd255, 8'd1, 8'($urandom_range(255))};
		foreach (settings[j]) begin
			write_tolerance(settings[j]);
			tx_idle_pct = 27;
			rx_stall_pct = 27;
			for (int n = 0; n < 40; n++) begin
				if (n < 8)
					send_query(make_query(0, 0, 0, 1600, 0, 0, 1600 + 8 * n, 0, 0, 4));
				else
					send_query(random_query());
			end
			drain();
		end
	endtask

	task automatic test_random_traffic(int count, int tx_pct, int rx_pct);
		tx_idle_pct = tx_pct;
		rx_stall_pct = rx_pct;
		for (int n = 0; n < count; n++)
			send_query(random_query());
		drain();
	endtask

	// hold the receiver off long enough for the pipeline to fill and push
	// back on the input, keep offering queries throughout
	task automatic test_backpressure;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		hold_len = 4 * PIPE_DEPTH;
		hold_request++;
		for (int n = 0; n < 3 * PIPE_DEPTH; n++)
			send_query(random_query());
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		start_x = '0;
		start_y = '0;
		start_z = '0;
		end_x = '0;
		end_y = '0;
		end_z = '0;
		center_x = '0;
		center_y = '0;
		center_z = '0;
		radius = '0;
		tol_now = ssi_pkg::TOL_RESET;
		error_count = 0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		hold_request = 0;
		hold_len = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed tests at the reset tolerance and at 255, then the sweep, then random phases and backpressure
		test_directed();
		write_tolerance(8'd255);
		test_directed();
		test_tolerance_sweep();
		write_tolerance(ssi_pkg::TOL_RESET);
		test_random_traffic(150, 0, 0);
		test_random_traffic(150, 61, 0);
		test_random_traffic(150, 0, 61);
		write_tolerance(8'($urandom_range(255)));
		test_random_traffic(150, 27, 27);
		test_backpressure();
		test_random_traffic(60, 0, 0);

		if (error_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("tb_top: FAIL");
		$finish;
	end

endmodule
